>>> rtl/lldpv_pkg.sv
// shared types, codes and constants of the lldp pdu validator
`default_nettype none

package lldpv_pkg;

	// largest pdu in bytes; offset counter saturates here
	localparam int MAX_PDU_BYTES = 1500;
	localparam int OFS_W         = $clog2(MAX_PDU_BYTES + 1);

	// register file
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;
	localparam logic [1:0] REG_CHASSIS_MIN = 2'd0;
	localparam logic [1:0] REG_CHASSIS_MAX = 2'd1;
	localparam logic [1:0] REG_PORT_MIN    = 2'd2;
	localparam logic [1:0] REG_PORT_MAX    = 2'd3;

	// tlv type codes
	localparam logic [6:0] TLV_END      = 7'd0;
	localparam logic [6:0] TLV_CHASSIS  = 7'd1;
	localparam logic [6:0] TLV_PORT     = 7'd2;
	localparam logic [6:0] TLV_TTL      = 7'd3;
	localparam logic [6:0] TLV_OPT_LO   = 7'd4;
	localparam logic [6:0] TLV_OPT_HI   = 7'd8;
	localparam logic [6:0] TLV_ORG      = 7'd127;

	// tlv position inside the pdu
	localparam logic [1:0] ORD_CHASSIS  = 2'd0;
	localparam logic [1:0] ORD_PORT     = 2'd1;
	localparam logic [1:0] ORD_TTL      = 2'd2;
	localparam logic [1:0] ORD_OPTIONAL = 2'd3;

	// result kinds
	localparam logic [1:0] KIND_CHASSIS = 2'd0;
	localparam logic [1:0] KIND_PORT    = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	typedef enum logic [9:0] {
		PH_HDR_HI = 10'b00_0000_0001,
		PH_HDR_LO = 10'b00_0000_0010,
		PH_CH_SUB = 10'b00_0000_0100,
		PH_CH_ID  = 10'b00_0000_1000,
		PH_PT_SUB = 10'b00_0001_0000,
		PH_PT_ID  = 10'b00_0010_0000,
		PH_TTL_HI = 10'b00_0100_0000,
		PH_TTL_LO = 10'b00_1000_0000,
		PH_SKIP   = 10'b01_0000_0000,
		PH_IGNORE = 10'b10_0000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} pdu_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  id_byte;
		logic        status;
		logic [7:0]  chassis_subtype;
		logic [7:0]  chassis_id_len;
		logic [7:0]  port_subtype;
		logic [7:0]  port_id_len;
		logic [15:0] ttl_seconds;
	} result_t;

	typedef struct packed {
		logic [7:0] chassis_min_len;
		logic [7:0] chassis_max_len;
		logic [7:0] port_min_len;
		logic [7:0] port_max_len;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/lldpv_parser.sv
// tlv parser state and per-byte next-state logic
`default_nettype none

module lldpv_parser (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    accept,
	input  lldpv_pkg::pdu_t        pdu,
	input  lldpv_pkg::cfg_t        cfg,
	output logic                   res_vld,
	output lldpv_pkg::result_t     res
);

	lldpv_pkg::phase_t phase_q, n_phase, cur;
	logic [1:0]                  ord_q, n_ord;
	logic [7:0]                  hh_q, n_hh;
	logic [8:0]                  bl_q, n_bl, bl_dec, len;
	logic [lldpv_pkg::OFS_W-1:0] ofs_q, n_ofs;
	logic [7:0]                  csub_q, n_csub, clen_q, n_clen;
	logic [7:0]                  psub_q, n_psub, plen_q, n_plen;
	logic [15:0]                 ttl_q, n_ttl;
	logic                        err_q, n_err, end_q, n_end;
	logic                        ovf, is_body, emit;
	lldpv_pkg::phase_t           body_tgt;
	logic [6:0]                  ttype;
	logic [7:0]                  b;

	assign b      = pdu.data_byte;
	assign len    = {hh_q[0], b};
	assign ttype  = hh_q[7:1];
	assign bl_dec = bl_q - 9'd1;

	always_comb begin
		n_phase  = phase_q;
		n_ord    = ord_q;
		n_hh     = hh_q;
		n_bl     = bl_q;
		n_ofs    = ofs_q;
		n_csub   = csub_q;
		n_clen   = clen_q;
		n_psub   = psub_q;
		n_plen   = plen_q;
		n_ttl    = ttl_q;
		n_err    = err_q;
		n_end    = end_q;
		is_body  = 1'b0;
		body_tgt = phase_q;
		res      = '0;

		// overlong pdu before the end tlv
		ovf = !end_q && !err_q && (ofs_q >= lldpv_pkg::OFS_W'(lldpv_pkg::MAX_PDU_BYTES));
		cur = ovf ? lldpv_pkg::PH_IGNORE : phase_q;
		if (ovf) begin
			n_err   = 1'b1;
			n_phase = lldpv_pkg::PH_IGNORE;
		end
		if (ofs_q < lldpv_pkg::OFS_W'(lldpv_pkg::MAX_PDU_BYTES)) begin
			n_ofs = ofs_q + 1'b1;
		end

		case (cur)
			lldpv_pkg::PH_HDR_HI: begin
				n_hh    = b;
				n_phase = lldpv_pkg::PH_HDR_LO;
			end
			lldpv_pkg::PH_HDR_LO: begin
				n_bl = len;
				case (ord_q)
					lldpv_pkg::ORD_CHASSIS: begin
						if (ttype != lldpv_pkg::TLV_CHASSIS
							|| len < ({1'b0, cfg.chassis_min_len} + 9'd1)
							|| len > ({1'b0, cfg.chassis_max_len} + 9'd1)) begin
							n_err   = 1'b1;
							n_phase = lldpv_pkg::PH_IGNORE;
						end else begin
							n_phase = lldpv_pkg::PH_CH_SUB;
						end
					end
					lldpv_pkg::ORD_PORT: begin
						if (ttype != lldpv_pkg::TLV_PORT
							|| len < ({1'b0, cfg.port_min_len} + 9'd1)
							|| len > ({1'b0, cfg.port_max_len} + 9'd1)) begin
							n_err   = 1'b1;
							n_phase = lldpv_pkg::PH_IGNORE;
						end else begin
							n_phase = lldpv_pkg::PH_PT_SUB;
						end
					end
					lldpv_pkg::ORD_TTL: begin
						if (ttype != lldpv_pkg::TLV_TTL || len != 9'd2) begin
							n_err   = 1'b1;
							n_phase = lldpv_pkg::PH_IGNORE;
						end else begin
							n_phase = lldpv_pkg::PH_TTL_HI;
						end
					end
					default: begin
						if (ttype == lldpv_pkg::TLV_END) begin
							if (len != 9'd0) begin
								n_err = 1'b1;
							end else begin
								n_end = 1'b1;
							end
							n_phase = lldpv_pkg::PH_IGNORE;
						end else if ((ttype >= lldpv_pkg::TLV_OPT_LO
							&& ttype <= lldpv_pkg::TLV_OPT_HI)
							|| ttype == lldpv_pkg::TLV_ORG) begin
							n_phase = (len == 9'd0) ? lldpv_pkg::PH_HDR_HI
							                        : lldpv_pkg::PH_SKIP;
						end else begin
							n_err   = 1'b1;
							n_phase = lldpv_pkg::PH_IGNORE;
						end
					end
				endcase
			end
			lldpv_pkg::PH_CH_SUB: begin
				n_csub   = b;
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_CH_ID;
			end
			lldpv_pkg::PH_CH_ID: begin
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_CH_ID;
			end
			lldpv_pkg::PH_PT_SUB: begin
				n_psub   = b;
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_PT_ID;
			end
			lldpv_pkg::PH_PT_ID: begin
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_PT_ID;
			end
			lldpv_pkg::PH_TTL_HI: begin
				n_ttl    = {b, 8'd0};
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_TTL_LO;
			end
			lldpv_pkg::PH_TTL_LO: begin
				n_ttl    = {ttl_q[15:8], b};
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_TTL_LO;
			end
			lldpv_pkg::PH_SKIP: begin
				is_body  = 1'b1;
				body_tgt = lldpv_pkg::PH_SKIP;
			end
			default: begin
			end
		endcase

		// end of a body byte: back to header parsing when the tlv is used up
		if (is_body) begin
			n_bl = bl_dec;
			if (bl_dec == 9'd0) begin
				n_phase = lldpv_pkg::PH_HDR_HI;
				if (ord_q != lldpv_pkg::ORD_OPTIONAL) begin
					n_ord = ord_q + 2'd1;
				end
			end else begin
				n_phase = body_tgt;
			end
		end

		emit = !pdu.last_byte
			&& (cur == lldpv_pkg::PH_CH_ID || cur == lldpv_pkg::PH_PT_ID);

		if (pdu.last_byte) begin
			res.kind            = lldpv_pkg::KIND_VERDICT;
			res.status          = n_err || !n_end;
			res.chassis_subtype = n_csub;
			res.chassis_id_len  = n_clen;
			res.port_subtype    = n_psub;
			res.port_id_len     = n_plen;
			res.ttl_seconds     = n_ttl;
			n_phase = lldpv_pkg::PH_HDR_HI;
			n_ord   = '0;
			n_hh    = '0;
			n_bl    = '0;
			n_ofs   = '0;
			n_csub  = '0;
			n_clen  = '0;
			n_psub  = '0;
			n_plen  = '0;
			n_ttl   = '0;
			n_err   = 1'b0;
			n_end   = 1'b0;
		end else if (emit) begin
			res.id_byte = b;
			if (cur == lldpv_pkg::PH_CH_ID) begin
				res.kind = lldpv_pkg::KIND_CHASSIS;
				n_clen   = clen_q + 8'd1;
			end else begin
				res.kind = lldpv_pkg::KIND_PORT;
				n_plen   = plen_q + 8'd1;
			end
		end

		res_vld = pdu.last_byte || emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lldpv_pkg::PH_HDR_HI;
			ord_q   <= '0;
			hh_q    <= '0;
			bl_q    <= '0;
			ofs_q   <= '0;
			csub_q  <= '0;
			clen_q  <= '0;
			psub_q  <= '0;
			plen_q  <= '0;
			ttl_q   <= '0;
			err_q   <= 1'b0;
			end_q   <= 1'b0;
		end else if (accept) begin
			phase_q <= n_phase;
			ord_q   <= n_ord;
			hh_q    <= n_hh;
			bl_q    <= n_bl;
			ofs_q   <= n_ofs;
			csub_q  <= n_csub;
			clen_q  <= n_clen;
			psub_q  <= n_psub;
			plen_q  <= n_plen;
			ttl_q   <= n_ttl;
			err_q   <= n_err;
			end_q   <= n_end;
		end
	end

	a_end_parks: assert property (@(posedge clk) disable iff (!arst_n)
		end_q |-> phase_q == lldpv_pkg::PH_IGNORE)
		else $error("end tlv seen but parser not parked");
	a_err_parks: assert property (@(posedge clk) disable iff (!arst_n)
		err_q |-> phase_q == lldpv_pkg::PH_IGNORE)
		else $error("error flagged but parser not parked");
	a_ofs_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ofs_q <= lldpv_pkg::OFS_W'(lldpv_pkg::MAX_PDU_BYTES))
		else $error("byte offset past saturation");
	a_verdict_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pdu.last_byte |=> ofs_q == '0 && !err_q && !end_q)
		else $error("pdu state not cleared after verdict");

endmodule

`default_nettype wire

>>> rtl/lldp_pdu_validator_unit.sv
// top level of the lldp pdu validator: register file, parser and result buffer
`default_nettype none

// LLDP PDU validator. A PDU enters one byte per request on the pdu channel, the
// last byte flagged by last_byte, and one byte is taken every cycle as long as
// the result side keeps up. Each chassis or port ID byte produces one result
// (kind 0 or 1) and the last byte of the PDU produces the verdict (kind 2)
// carrying status, the ID subtypes, the number of ID bytes emitted and the TTL;
// other bytes produce no result. A result enters the result register in the
// cycle after its byte is accepted when that register is free, else it waits in
// the skid entry. The result side is a two-entry buffer
// (output register plus skid), so pdu_stall rises only when both entries are
// full; a single combinational parse step sits between the parser state
// registers and the result register. The ID length limits are
// written through the APB port (chassis min at 0x0, chassis max at 0x4, port
// min at 0x8, port max at 0xc, low 8 bits used) and should only be changed
// while no PDU is in flight.

module lldp_pdu_validator_unit (
	input  wire                                clk,
	input  wire                                arst_n,
	// configuration port
	input  wire                                psel,
	input  wire                                penable,
	input  wire                                pwrite,
	input  wire  [lldpv_pkg::APB_AW-1:0]       paddr,
	input  wire  [lldpv_pkg::APB_DW-1:0]       pwdata,
	output logic [lldpv_pkg::APB_DW-1:0]       prdata,
	output logic                               pready,
	// pdu byte stream
	input  wire                                pdu_valid,
	output logic                               pdu_stall,
	input  lldpv_pkg::pdu_t                    pdu,
	// results
	output logic                               result_valid,
	input  wire                                result_stall,
	output lldpv_pkg::result_t                 result
);

	lldpv_pkg::cfg_t    cfg_q;
	lldpv_pkg::result_t res, out_q, skid_q;
	logic               res_vld, out_vld_q, skid_vld_q;
	logic               pdu_acc, push, out_free, cfg_wr;
	logic [1:0]         reg_idx;

	// register file, word addressed
	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chassis_min_len <= 8'd1;
			cfg_q.chassis_max_len <= 8'd255;
			cfg_q.port_min_len    <= 8'd1;
			cfg_q.port_max_len    <= 8'd255;
		end else if (cfg_wr) begin
			case (reg_idx)
				lldpv_pkg::REG_CHASSIS_MIN: cfg_q.chassis_min_len <= pwdata[7:0];
				lldpv_pkg::REG_CHASSIS_MAX: cfg_q.chassis_max_len <= pwdata[7:0];
				lldpv_pkg::REG_PORT_MIN:    cfg_q.port_min_len    <= pwdata[7:0];
				lldpv_pkg::REG_PORT_MAX:    cfg_q.port_max_len    <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// read back, zero extended
	always_comb begin
		case (reg_idx)
			lldpv_pkg::REG_CHASSIS_MIN: prdata = {24'd0, cfg_q.chassis_min_len};
			lldpv_pkg::REG_CHASSIS_MAX: prdata = {24'd0, cfg_q.chassis_max_len};
			lldpv_pkg::REG_PORT_MIN:    prdata = {24'd0, cfg_q.port_min_len};
			lldpv_pkg::REG_PORT_MAX:    prdata = {24'd0, cfg_q.port_max_len};
			default:                    prdata = '0;
		endcase
	end

	// a byte is taken whenever the skid entry is free
	assign pdu_stall = skid_vld_q;
	assign pdu_acc   = pdu_valid && !pdu_stall;

	lldpv_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (pdu_acc),
		.pdu     (pdu),
		.cfg     (cfg_q),
		.res_vld (res_vld),
		.res     (res)
	);

	assign push     = pdu_acc && res_vld;
	// output register empties or is taken this cycle
	assign out_free = !out_vld_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (out_free) begin
			// skid drains first; no new result can arrive while it is full
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= 1'b0;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_vld_q ? skid_q : res;
		end
		if (!out_free && push) begin
			skid_q <= res;
		end
	end

	assign result_valid = out_vld_q;
	assign result       = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> out_vld_q)
		else $error("skid entry held with empty output register");
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && result_stall |=> skid_vld_q && $stable(skid_q))
		else $error("skid entry overwritten while stalled");
	a_id_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != lldpv_pkg::KIND_VERDICT |-> !result.status
			&& result.ttl_seconds == 16'd0)
		else $error("verdict fields set on an id byte result");

endmodule

`default_nettype wire
